// ===== hdl/smb_pkg.sv =====
// Package for the spectrum magnitude binner.
// Holds the sequencer state type and the fixed field widths; depends on nothing.
`default_nettype none

package smb_pkg;

    localparam int DATA_W     = 32;
    localparam int SIZE_W     = 9;
    localparam int NUM_W      = 12;
    localparam int SUB_W      = 34;
    localparam int SQRT_STEPS = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_SUMSQ,
        ST_ROOT,
        ST_ACCUM,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/spectrum_magnitude_binner_top.sv =====
// Spectrum magnitude binner: magnitude, bin accumulation, average and peak tracking.
// One shared multiplier and one shared compare-subtract unit under a small sequencer.
// Depends on smb_pkg.
//
//   Port group   Direction  Handshake          Payload
//   s_*          in         s_valid/s_ready    real_part, imag_part, last_component
//   m_*          out        m_valid/m_ready    bin_average, bin_number, peak_average,
//                                              spectrum_end
//   cfg_*        in         cfg_we             bin_size
//
// A DC component is accepted in the idle state and is not accumulated. Any other component
// passes through the multiplier twice, then one add, 32 steps of the square root through
// the subtract unit and one accumulate. A component that closes a bin adds one step per bit
// of the bin sum (41 at default parameters) of restoring division through the same unit,
// plus one step to load the result register. The result register frees s_ready; only a new bin
// average waits for m_ready. Reset is synchronous; no clearing pass.
`default_nettype none

module spectrum_magnitude_binner_top #(
    parameter int MAX_BIN_SIZE = 256,
    parameter int MAX_BINS     = 4096
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    input  wire logic                             cfg_we,
    input  wire logic [smb_pkg::SIZE_W-1:0]       cfg_wdata,

    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic signed [smb_pkg::DATA_W-1:0] s_real_part,
    input  wire logic signed [smb_pkg::DATA_W-1:0] s_imag_part,
    input  wire logic                             s_last_component,

    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [smb_pkg::DATA_W-1:0]            m_bin_average,
    output logic [smb_pkg::NUM_W-1:0]             m_bin_number,
    output logic [smb_pkg::DATA_W-1:0]            m_peak_average,
    output logic                                  m_spectrum_end
);

    localparam int DW     = smb_pkg::DATA_W;
    localparam int CNT_W  = $clog2(MAX_BIN_SIZE + 1);
    localparam int SUM_W  = DW + CNT_W;
    localparam int BIN_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CMP_W  = CNT_W + smb_pkg::SIZE_W;
    localparam int STEP_W = $clog2(SUM_W + 1);
    localparam int WORK_W = 2 * DW;
    localparam int SW     = smb_pkg::SUB_W;

    smb_pkg::state_t state_reg, state_next;

    logic [smb_pkg::SIZE_W-1:0] bin_size_reg, bin_size_next;
    logic [DW-1:0]              re_abs_reg, re_abs_next;
    logic [DW-1:0]              im_abs_reg, im_abs_next;
    logic                       last_reg, last_next;
    logic [WORK_W-1:0]          work_reg, work_next;
    logic [WORK_W-1:0]          prod_reg, prod_next;
    logic [SW-1:0]              rem_reg, rem_next;
    logic [DW-1:0]              root_reg, root_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       at_dc_reg, at_dc_next;
    logic [BIN_W-1:0]           bin_reg, bin_next;
    logic [DW-1:0]              peak_reg, peak_next;
    logic                       m_valid_reg, m_valid_next;
    logic [DW-1:0]              m_avg_reg, m_avg_next;
    logic [smb_pkg::NUM_W-1:0]  m_num_reg, m_num_next;
    logic [DW-1:0]              m_peak_reg, m_peak_next;
    logic                       m_end_reg, m_end_next;

    logic                       s_fire;
    logic [DW-1:0]              mul_a;
    logic [WORK_W-1:0]          mul_out;
    logic [SW-1:0]              sub_a, sub_b;
    logic [SW:0]                diff;
    logic                       sub_ge;
    logic [CMP_W-1:0]           size_eff, cnt_inc;
    logic                       bin_close;
    logic [SUM_W-1:0]           sum_acc;
    logic                       out_slot;
    logic [BIN_W+smb_pkg::NUM_W-1:0] bin_ext;
    logic [DW-1:0]              re_u, im_u;

    assign s_ready  = (state_reg == smb_pkg::ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_slot = !m_valid_reg || m_ready;

    assign re_u = s_real_part;
    assign im_u = s_imag_part;

    // shared multiplier
    assign mul_a   = (state_reg == smb_pkg::ST_SQ_RE) ? re_abs_reg : im_abs_reg;
    assign mul_out = WORK_W'(mul_a) * WORK_W'(mul_a);

    // shared compare-subtract
    always_comb begin
        if (state_reg == smb_pkg::ST_ROOT) begin
            sub_a = {rem_reg[SW-3:0], work_reg[WORK_W-1 -: 2]};
            sub_b = {root_reg, 2'b01};
        end else begin
            sub_a = {rem_reg[SW-2:0], work_reg[WORK_W-1]};
            sub_b = SW'(cnt_reg);
        end
    end
    assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge = !diff[SW];

    always_comb begin
        if (bin_size_reg == '0) begin
            size_eff = CMP_W'(1);
        end else if (CMP_W'(bin_size_reg) > CMP_W'(MAX_BIN_SIZE)) begin
            size_eff = CMP_W'(MAX_BIN_SIZE);
        end else begin
            size_eff = CMP_W'(bin_size_reg);
        end
    end
    assign cnt_inc   = CMP_W'(cnt_reg) + CMP_W'(1);
    assign bin_close = (cnt_inc >= size_eff) || last_reg;
    assign sum_acc   = sum_reg + SUM_W'(root_reg);
    assign bin_ext   = {{smb_pkg::NUM_W{1'b0}}, bin_reg};

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            smb_pkg::ST_IDLE: begin
                if (s_fire && !at_dc_reg) begin
                    state_next = smb_pkg::ST_SQ_RE;
                end
            end
            smb_pkg::ST_SQ_RE: state_next = smb_pkg::ST_SQ_IM;
            smb_pkg::ST_SQ_IM: state_next = smb_pkg::ST_SUMSQ;
            smb_pkg::ST_SUMSQ: state_next = smb_pkg::ST_ROOT;
            smb_pkg::ST_ROOT: begin
                if (step_reg == '0) begin
                    state_next = smb_pkg::ST_ACCUM;
                end
            end
            smb_pkg::ST_ACCUM: begin
                state_next = bin_close ? smb_pkg::ST_DIV : smb_pkg::ST_IDLE;
            end
            smb_pkg::ST_DIV: begin
                if (step_reg == '0) begin
                    state_next = smb_pkg::ST_OUT;
                end
            end
            smb_pkg::ST_OUT: begin
                if (out_slot) begin
                    state_next = smb_pkg::ST_IDLE;
                end
            end
            default: state_next = smb_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        bin_size_next = cfg_we ? cfg_wdata : bin_size_reg;
        re_abs_next   = re_abs_reg;
        im_abs_next   = im_abs_reg;
        last_next     = last_reg;
        work_next     = work_reg;
        prod_next     = prod_reg;
        rem_next      = rem_reg;
        root_next     = root_reg;
        step_next     = step_reg;
        sum_next      = sum_reg;
        cnt_next      = cnt_reg;
        at_dc_next    = at_dc_reg;
        bin_next      = bin_reg;
        peak_next     = peak_reg;
        m_valid_next  = m_ready ? 1'b0 : m_valid_reg;
        m_avg_next    = m_avg_reg;
        m_num_next    = m_num_reg;
        m_peak_next   = m_peak_reg;
        m_end_next    = m_end_reg;

        case (state_reg)
            smb_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (at_dc_reg) begin
                        at_dc_next = s_last_component;
                    end
                    re_abs_next = s_real_part[DW-1] ? (~re_u + DW'(1)) : re_u;
                    im_abs_next = s_imag_part[DW-1] ? (~im_u + DW'(1)) : im_u;
                    last_next   = s_last_component;
                end
            end
            smb_pkg::ST_SQ_RE: work_next = mul_out;
            smb_pkg::ST_SQ_IM: prod_next = mul_out;
            smb_pkg::ST_SUMSQ: begin
                work_next = work_reg + prod_reg;
                rem_next  = '0;
                root_next = '0;
                step_next = STEP_W'(smb_pkg::SQRT_STEPS - 1);
            end
            smb_pkg::ST_ROOT: begin
                rem_next  = sub_ge ? diff[SW-1:0] : sub_a;
                root_next = {root_reg[DW-2:0], sub_ge};
                work_next = {work_reg[WORK_W-3:0], 2'b00};
                step_next = step_reg - STEP_W'(1);
            end
            smb_pkg::ST_ACCUM: begin
                sum_next = sum_acc;
                cnt_next = cnt_inc[CNT_W-1:0];
                if (bin_close) begin
                    work_next = WORK_W'(sum_acc) << (WORK_W - SUM_W);
                    rem_next  = '0;
                    root_next = '0;
                    step_next = STEP_W'(SUM_W - 1);
                end
            end
            smb_pkg::ST_DIV: begin
                rem_next  = sub_ge ? diff[SW-1:0] : sub_a;
                root_next = {root_reg[DW-2:0], sub_ge};
                work_next = {work_reg[WORK_W-2:0], 1'b0};
                step_next = step_reg - STEP_W'(1);
            end
            smb_pkg::ST_OUT: begin
                if (out_slot) begin
                    peak_next    = (root_reg > peak_reg) ? root_reg : peak_reg;
                    m_valid_next = 1'b1;
                    m_avg_next   = root_reg;
                    m_num_next   = bin_ext[smb_pkg::NUM_W-1:0];
                    m_peak_next  = (root_reg > peak_reg) ? root_reg : peak_reg;
                    m_end_next   = last_reg;
                    sum_next     = '0;
                    cnt_next     = '0;
                    if (last_reg) begin
                        bin_next   = '0;
                        at_dc_next = 1'b1;
                    end else if (bin_reg == BIN_W'(MAX_BINS - 1)) begin
                        bin_next = '0;
                    end else begin
                        bin_next = bin_reg + BIN_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= smb_pkg::ST_IDLE;
            bin_size_reg <= smb_pkg::SIZE_W'(1);
            sum_reg      <= '0;
            cnt_reg      <= '0;
            at_dc_reg    <= 1'b1;
            bin_reg      <= '0;
            peak_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            bin_size_reg <= bin_size_next;
            sum_reg      <= sum_next;
            cnt_reg      <= cnt_next;
            at_dc_reg    <= at_dc_next;
            bin_reg      <= bin_next;
            peak_reg     <= peak_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        re_abs_reg <= re_abs_next;
        im_abs_reg <= im_abs_next;
        last_reg   <= last_next;
        work_reg   <= work_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        step_reg   <= step_next;
        m_avg_reg  <= m_avg_next;
        m_num_reg  <= m_num_next;
        m_peak_reg <= m_peak_next;
        m_end_reg  <= m_end_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_bin_average  = m_avg_reg;
    assign m_bin_number   = m_num_reg;
    assign m_peak_average = m_peak_reg;
    assign m_spectrum_end = m_end_reg;

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == smb_pkg::ST_OUT))
        else $error("result appeared outside the output step");

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(cnt_reg) <= CMP_W'(MAX_BIN_SIZE))
        else $error("bin fill count above the largest bin size");

    a_div_remainder: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == smb_pkg::ST_DIV) |-> (cnt_reg != '0) && (rem_reg < SW'(cnt_reg)))
        else $error("division remainder not below the divisor");

    a_peak_covers: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_peak_average >= m_bin_average))
        else $error("peak below the current bin average");

    a_peak_monotone: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (peak_reg >= $past(peak_reg)))
        else $error("peak decreased");

endmodule

`default_nettype wire
